// ===== rtl/wis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_pkg: shared types and constants of the weighted index sampler
// Item kinds, result status codes, the control word that travels between the
// front and the back end, and the fixed widths of the running sums.
// ----------------------------------------------------------------------------
package wis_pkg;

	// Running sums and the total saturate at this width
	localparam int unsigned SUM_W = 26;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Width of the weight floor register
	localparam int unsigned FLOOR_W = 16;

	// Uniform fraction is widened to this many bits and split in two halves
	localparam int unsigned U_EXT_W  = 48;
	localparam int unsigned U_HALF_W = 24;

	// Item kind carried in tuser
	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_e;

	// Result status carried in tuser
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e;

	// Control word of one queued item
	typedef struct packed {
		logic first;
		op_e  op;
	} item_ctl_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SUM,
		BK_ISSUE,
		BK_CMP
	} bk_state_e;

endpackage

// ===== rtl/wis_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wis_ram #(
	parameter int unsigned WIDTH = 26,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/wis_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_front: input side of the weighted index sampler
// Holds the weight floor, accepts items, raises load weights to the floor and
// queues items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wis_front import wis_pkg::*; #(
	parameter int unsigned WEIGHT_BITS  = 16,
	parameter int unsigned UNIFORM_BITS = 32,
	localparam int unsigned CW = (WEIGHT_BITS > FLOOR_W) ? WEIGHT_BITS : FLOOR_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [FLOOR_W-1:0]      cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_op,
	input  logic                    in_first,
	input  logic [WEIGHT_BITS-1:0]  in_weight,
	input  logic [UNIFORM_BITS-1:0] in_uniform,
	output logic                    item_valid,
	input  logic                    item_ready,
	output item_ctl_t               item_ctl,
	output logic [CW-1:0]           item_weight,
	output logic [UNIFORM_BITS-1:0] item_uniform
);

	logic [FLOOR_W-1:0]      floor_q;
	item_ctl_t               ctl_q [2];
	logic [CW-1:0]           wgt_q [2];
	logic [UNIFORM_BITS-1:0] uni_q [2];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              fill_q;
	logic                    push;
	logic                    pop;
	logic [CW-1:0]           w_ext;
	logic [CW-1:0]           f_ext;
	logic [CW-1:0]           w_clamp;
	item_ctl_t               ctl_in;

	// Weight floor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= '0;
		end else if (cfg_wen) begin
			floor_q <= cfg_wdata;
		end
	end

	// Raise the weight to the floor and classify the item
	assign w_ext   = CW'(in_weight);
	assign f_ext   = CW'(floor_q);
	assign w_clamp = (w_ext < f_ext) ? f_ext : w_ext;
	assign ctl_in  = '{first: in_first, op: op_e'(in_op)};

	assign in_ready   = (fill_q != 2'd2);
	assign item_valid = (fill_q != 2'd0);
	assign push       = in_valid && in_ready;
	assign pop        = item_valid && item_ready;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q] <= ctl_in;
			wgt_q[wr_ptr_q] <= w_clamp;
			uni_q[wr_ptr_q] <= in_uniform;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	assign item_ctl     = ctl_q[rd_ptr_q];
	assign item_weight  = wgt_q[rd_ptr_q];
	assign item_uniform = uni_q[rd_ptr_q];

endmodule

// ===== rtl/wis_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_back: execution side of the weighted index sampler
// Appends running sums for load items and runs the scaled target computation
// and the binary search over the running-sum memory for sample items.
// ----------------------------------------------------------------------------
module wis_back import wis_pkg::*; #(
	parameter int unsigned TABLE_DEPTH  = 1024,
	parameter int unsigned WEIGHT_BITS  = 16,
	parameter int unsigned UNIFORM_BITS = 32,
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH),
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int unsigned CW    = (WEIGHT_BITS > FLOOR_W) ? WEIGHT_BITS : FLOOR_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  item_ctl_t               item_ctl,
	input  logic [CW-1:0]           item_weight,
	input  logic [UNIFORM_BITS-1:0] item_uniform,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic [IDX_W-1:0]        res_index,
	output logic [SUM_W-1:0]        res_total,
	output logic [CNT_W-1:0]        res_entries,
	output status_e                 res_status
);

	localparam int unsigned ADD_W  = ((CW > SUM_W) ? CW : SUM_W) + 1;
	localparam int unsigned PART_W = SUM_W + U_HALF_W;
	localparam int unsigned PROD_W = SUM_W + U_EXT_W;

	bk_state_e          state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   total_q;
	logic [U_EXT_W-1:0] uni_q;
	logic [PART_W-1:0]  p_hi_q, p_lo_q;
	logic [SUM_W-1:0]   target_q;
	logic [IDX_W-1:0]   lo_q, hi_q, mid_q;
	logic               res_valid_q;
	logic [IDX_W-1:0]   res_index_q;
	status_e            res_status_q;

	logic               slot_free;
	logic               take;
	logic               is_load;
	logic               samp_go;
	logic [CNT_W-1:0]   base_cnt;
	logic [SUM_W-1:0]   base_total;
	logic               full;
	logic [ADD_W-1:0]   sum_raw;
	logic [SUM_W-1:0]   sum_sat;
	logic [PROD_W-1:0]  prod;
	logic               rd_hit;
	logic [IDX_W-1:0]   lo_n, hi_n;
	logic [IDX_W-1:0]   mid_a, mid_b;
	logic               ram_we;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [SUM_W-1:0]   ram_rdata;
	logic               fin;
	logic [IDX_W-1:0]   fin_idx;

	// Take an item only when idle and the result slot is free by the next edge
	assign slot_free  = !res_valid_q || res_ready;
	assign item_ready = (state_q == BK_IDLE) && slot_free;
	assign take       = item_valid && item_ready;
	assign is_load    = (item_ctl.op == OP_LOAD);
	assign samp_go    = take && !is_load && (cnt_q != '0) && (total_q != '0);

	// Load path: optional restart, full check, saturating append
	assign base_cnt   = item_ctl.first ? '0 : cnt_q;
	assign base_total = item_ctl.first ? '0 : total_q;
	assign full       = (base_cnt == CNT_W'(TABLE_DEPTH));
	assign sum_raw    = ADD_W'(base_total) + ADD_W'(item_weight);
	assign sum_sat    = (sum_raw > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_raw[SUM_W-1:0];
	assign ram_we     = take && is_load && !full;

	// Target: recombine the two partial products and drop the fraction bits
	assign prod = {p_hi_q, {U_HALF_W{1'b0}}} + PROD_W'(p_lo_q);

	// Search step: narrow the interval from the returned running sum
	assign rd_hit = (ram_rdata > target_q);
	assign lo_n   = rd_hit ? lo_q : mid_q + 1'b1;
	assign hi_n   = rd_hit ? mid_q : hi_q;
	assign mid_a  = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_b  = lo_n + ((hi_n - lo_n) >> 1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (samp_go) state_d = BK_MUL;
			BK_MUL:   state_d = BK_SUM;
			BK_SUM:   state_d = BK_ISSUE;
			BK_ISSUE: state_d = fin ? BK_IDLE : BK_CMP;
			BK_CMP:   state_d = fin ? BK_IDLE : BK_CMP;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Memory read issue and search completion
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mid_a;
		fin       = 1'b0;
		fin_idx   = lo_q;
		unique case (state_q)
			BK_ISSUE: begin
				if (lo_q < hi_q) begin
					ram_re = 1'b1;
				end else begin
					fin = 1'b1;
				end
			end
			BK_CMP: begin
				ram_raddr = mid_b;
				fin_idx   = lo_n;
				if (lo_n < hi_n) begin
					ram_re = 1'b1;
				end else begin
					fin = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			total_q     <= '0;
		end else begin
			state_q <= state_d;
			if (fin || (take && !samp_go)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (take && is_load && !full) begin
				cnt_q   <= base_cnt + 1'b1;
				total_q <= sum_sat;
			end
		end
	end

	// Datapath and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			uni_q         <= U_EXT_W'(item_uniform);
			res_index_q   <= '0;
			res_status_q  <= is_load ? (full ? ST_FULL : ST_OK) : ST_EMPTY;
		end
		if (fin) begin
			res_index_q  <= fin_idx;
			res_status_q <= ST_OK;
		end
		if (state_q == BK_MUL) begin
			p_hi_q <= total_q * uni_q[U_EXT_W-1:U_HALF_W];
			p_lo_q <= total_q * uni_q[U_HALF_W-1:0];
		end
		if (state_q == BK_SUM) begin
			target_q <= prod[UNIFORM_BITS +: SUM_W];
			lo_q     <= '0;
			hi_q     <= IDX_W'(cnt_q - 1'b1);
		end
		if (state_q == BK_CMP) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
		if (ram_re) begin
			mid_q <= ram_raddr;
		end
	end

	// Running-sum memory
	wis_ram #(
		.WIDTH(SUM_W),
		.DEPTH(TABLE_DEPTH)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (base_cnt[IDX_W-1:0]),
		.wdata (sum_sat),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_valid   = res_valid_q;
	assign res_index   = res_index_q;
	assign res_status  = res_status_q;
	assign res_total   = total_q;
	assign res_entries = cnt_q;

endmodule

// ===== rtl/weighted_index_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_index_sampler: inverse-CDF discrete sampler
// Builds a table of running sums from loaded weights and draws an index by
// binary search of a scaled uniform fraction over that table.
//
//  channel  direction  tdata (low bit up)                 tuser (low bit up)
//  s_axis   in         weight, uniform                    op, first
//  m_axis   out        index, total, entries              status
//  cfg      in         cfg_wdata = weight floor, on cfg_wen
//
// A load item is taken and answered from the idle state of the back end. A
// sample item is taken, then forms the two partial products, then the target,
// then issues the first memory read and runs one search step per read of the
// single read port of the running-sum memory. A sample on an empty or all-zero
// table gets an empty status from the idle state. The two-entry queue takes
// items until it is full while the back end works or its result is stalled.
// Reset clears the table count, total and floor; memory needs no clearing pass.
// ----------------------------------------------------------------------------
module weighted_index_sampler import wis_pkg::*; #(
	parameter int unsigned TABLE_DEPTH  = 1024,
	parameter int unsigned WEIGHT_BITS  = 16,
	parameter int unsigned UNIFORM_BITS = 32,
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH),
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int unsigned IN_W  = ((WEIGHT_BITS + UNIFORM_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((IDX_W + SUM_W + CNT_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [FLOOR_W-1:0] cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // weight, uniform
	input  logic [1:0]         s_tuser,   // op, first
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // index, total, entries
	output logic [1:0]         m_tuser    // status
);

	localparam int unsigned CW = (WEIGHT_BITS > FLOOR_W) ? WEIGHT_BITS : FLOOR_W;

	logic                    item_valid;
	logic                    item_ready;
	item_ctl_t               item_ctl;
	logic [CW-1:0]           item_weight;
	logic [UNIFORM_BITS-1:0] item_uniform;
	logic [IDX_W-1:0]        res_index;
	logic [SUM_W-1:0]        res_total;
	logic [CNT_W-1:0]        res_entries;
	status_e                 res_status;

	// Accept, clamp and queue
	wis_front #(
		.WEIGHT_BITS (WEIGHT_BITS),
		.UNIFORM_BITS(UNIFORM_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (s_tuser[0]),
		.in_first    (s_tuser[1]),
		.in_weight   (s_tdata[WEIGHT_BITS-1:0]),
		.in_uniform  (s_tdata[WEIGHT_BITS +: UNIFORM_BITS]),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item_ctl    (item_ctl),
		.item_weight (item_weight),
		.item_uniform(item_uniform)
	);

	// Execute loads and samples
	wis_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.WEIGHT_BITS (WEIGHT_BITS),
		.UNIFORM_BITS(UNIFORM_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item_ctl    (item_ctl),
		.item_weight (item_weight),
		.item_uniform(item_uniform),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_index   (res_index),
		.res_total   (res_total),
		.res_entries (res_entries),
		.res_status  (res_status)
	);

	// Pack the result item
	assign m_tdata = OUT_W'({res_entries, res_total, res_index});
	assign m_tuser = res_status;

endmodule

// ===== rtl/wis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wis_checker: port-level checks of the weighted index sampler
// Watches the result channel for stalls and for status and field consistency.
// ----------------------------------------------------------------------------
module wis_checker import wis_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 1024,
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH),
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int unsigned OUT_W = ((IDX_W + SUM_W + CNT_W + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [1:0]       m_tuser
);

	logic [IDX_W-1:0] r_index;
	logic [SUM_W-1:0] r_total;
	logic [CNT_W-1:0] r_entries;

	assign r_index   = m_tdata[IDX_W-1:0];
	assign r_total   = m_tdata[IDX_W +: SUM_W];
	assign r_entries = m_tdata[IDX_W + SUM_W +: CNT_W];

	// Hold a stalled result item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result item changed");

	// A dropped load only happens on a full table
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> r_entries == CNT_W'(TABLE_DEPTH) && r_index == '0)
		else $error("load dropped on a table that is not full");

	// An empty status needs an empty or all-zero table
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> r_index == '0 && (r_entries == '0 || r_total == '0))
		else $error("empty status on a usable table");

	// A chosen index lies inside the table
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK && r_index != '0 |-> CNT_W'(r_index) < r_entries)
		else $error("sample index beyond table");

endmodule

bind weighted_index_sampler wis_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_wis_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
